### rtl/dsp_pkg.sv
// Shared types and constants for the shortest-path block.
package dsp_pkg;

    localparam int NODE_W = 5;
    localparam int DIST_W = 21;
    localparam logic [DIST_W-1:0] DIST_SAT = 21'd2097151;

    typedef enum logic [1:0]
    {
        MODE_SET   = 2'd0,
        MODE_SOLVE = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef struct packed
    {
        logic init;
        logic shift;
    } cell_ctrl_t;

endpackage

### rtl/dsp_cell.sv
// One node cell of the rotating ring: distance estimate, reached and open marks.
module dsp_cell
    import dsp_pkg::*;
#(
    parameter int DW = 21
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cell_ctrl_t    ctrl,
    input  logic          init_reached,
    input  logic [DW-1:0] in_dist,
    input  logic          in_reached,
    input  logic          in_open,
    output logic [DW-1:0] est,
    output logic          reached,
    output logic          open
);

    logic [DW-1:0] dist_reg;
    logic          reached_reg;
    logic          open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reached_reg <= 1'b0;
            open_reg    <= 1'b0;
        end
        else if (ctrl.init)
        begin
            reached_reg <= init_reached;
            open_reg    <= 1'b1;
        end
        else if (ctrl.shift)
        begin
            reached_reg <= in_reached;
            open_reg    <= in_open;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.init)
            dist_reg <= '0;
        else if (ctrl.shift)
            dist_reg <= in_dist;
    end

    assign est     = dist_reg;
    assign reached = reached_reg;
    assign open    = open_reg;

endmodule

### rtl/dsp_edge_mem.sv
// Adjacency matrix storage: one write port, one registered read port.
module dsp_edge_mem
#(
    parameter int AW = 10,
    parameter int DW = 16
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/dijkstra_shortest_path_top.sv
// Shortest-path engine: edge matrix, ring of node cells, path walk and output.
//
// Input channel (in_valid/in_ready) takes one word per command: mode 0 writes an
// undirected edge weight into both directions, mode 2 clears the matrix, mode 1 solves from
// node_a to node_b. The config channel (cfg_valid/cfg_ready) writes node_count and
// is always ready.
// A solve streams the node ring past one head cell per cycle, one full rotation
// per Dijkstra round, after a load or prime state that starts the edge-row read.
// Up to n+1 rounds run, n being the active node count; the parents are then
// walked back from the destination and the result words emitted one at a time,
// each only after the one before has been taken.
// Result words (out_valid/out_ready) come source first; last marks the final one.
// An out-of-range source or destination node, or an unreachable destination, gives one word with unreachable set.
// A stalled receiver holds the result word; no new command is taken until every
// word of the solve has been delivered.
// After reset, and after a clear command, a sweep over all 2^(2*clog2(MAX_NODES))
// addresses (1024 for 32 nodes) zeroes the matrix while in_ready stays low.
module dijkstra_shortest_path_top
    import dsp_pkg::*;
#(
    parameter int MAX_NODES   = 32,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [5:0]          node_count,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          mode,
    input  logic [NODE_W-1:0]   node_a,
    input  logic [NODE_W-1:0]   node_b,
    input  logic [15:0]         weight,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [NODE_W-1:0]   node,
    output logic [DIST_W-1:0]   total_distance,
    output logic                unreachable,
    output logic                last
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = (NW + 1 > 7) ? NW + 1 : 7;
    localparam int SW = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
    localparam int DW = SW + NW;
    localparam int AW = 2 * NW;
    localparam int XW = (DW > DIST_W) ? DW : DIST_W;

    typedef enum logic [3:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_SET2,
        ST_LOAD,
        ST_PRIME,
        ST_PASS,
        ST_WALK,
        ST_WALK_WAIT,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_OUT
    } state_t;

    state_t          state_reg;
    logic [AW-1:0]   clr_reg;
    logic [AW-1:0]   set_addr_reg;
    logic [SW-1:0]   set_w_reg;
    logic [5:0]      nc_reg;
    logic [NW-1:0]   src_reg;
    logic [NW-1:0]   dst_reg;
    logic [NODE_W-1:0] dst5_reg;
    logic [NW-1:0]   k_reg;
    logic [NW-1:0]   u_reg;
    logic [DW-1:0]   du_reg;
    logic            have_u_reg;
    logic            found_reg;
    logic [NW-1:0]   best_reg;
    logic [DW-1:0]   best_dist_reg;
    logic [DW-1:0]   dst_dist_reg;
    logic            dst_reached_reg;
    logic [NW-1:0]   cur_reg;
    logic [CW-1:0]   len_reg;
    logic [NW-1:0]   e_idx_reg;
    logic            out_valid_reg;
    logic [NODE_W-1:0] node_reg;
    logic [DIST_W-1:0] dist_reg;
    logic            unr_reg;
    logic            last_reg;

    // Edge memory ports
    logic            em_we;
    logic [AW-1:0]   em_waddr;
    logic [SW-1:0]   em_wdata;
    logic [AW-1:0]   em_raddr;
    logic [SW-1:0]   em_rdata;

    // Parent and path memories
    logic [NW-1:0]   par_mem [MAX_NODES];
    logic [NW-1:0]   par_rdata_reg;
    logic [NW-1:0]   path_mem [MAX_NODES];
    logic [NW-1:0]   path_rdata_reg;

    // Ring
    cell_ctrl_t      cctrl;
    logic [DW-1:0]   c_dist    [MAX_NODES];
    logic            c_reached [MAX_NODES];
    logic            c_open    [MAX_NODES];
    logic [DW-1:0]   t_dist;
    logic            t_reached;
    logic            t_open;

    logic [CW-1:0]   nc_ext;
    logic [CW-1:0]   n_act;
    logic [CW-1:0]   a_ext;
    logic [CW-1:0]   b_ext;
    logic            in_acc;
    logic            active;
    logic [DW-1:0]   cand;
    logic            relax;
    logic            is_cand;
    logic            pass_found;
    logic [NW-1:0]   pass_best;
    logic [DW-1:0]   pass_best_dist;
    logic            pass_dst_reached;
    logic [XW-1:0]   dist_x;
    logic [DIST_W-1:0] dist_sat;
    logic [CW-1:0]   len_inc;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;

    assign nc_ext = CW'(nc_reg);
    assign n_act  = (nc_reg == 6'd0) ? CW'(1) :
                    ((nc_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : nc_ext);
    assign a_ext  = CW'(node_a);
    assign b_ext  = CW'(node_b);

    // Head cell processing: close, relax, then compete for next round
    assign active    = CW'(k_reg) < n_act;
    assign cand      = du_reg + DW'(em_rdata);
    assign relax     = have_u_reg && active && (em_rdata != '0) &&
                       (!c_reached[0] || cand < c_dist[0]);
    assign t_dist    = relax ? cand : c_dist[0];
    assign t_reached = c_reached[0] || relax;
    assign t_open    = c_open[0] && !(have_u_reg && active && k_reg == u_reg);
    assign is_cand   = active && t_open && t_reached &&
                       (!found_reg || t_dist < best_dist_reg);

    assign pass_found     = found_reg || is_cand;
    assign pass_best      = is_cand ? k_reg : best_reg;
    assign pass_best_dist = is_cand ? t_dist : best_dist_reg;
    assign pass_dst_reached = (k_reg == dst_reg) ? t_reached : dst_reached_reg;

    assign cctrl.init  = (state_reg == ST_LOAD);
    assign cctrl.shift = (state_reg == ST_PASS);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_NODES; gi++)
        begin : g_ring
            logic [DW-1:0] nb_dist;
            logic          nb_reached;
            logic          nb_open;
            if (gi == MAX_NODES - 1)
            begin : g_tail
                assign nb_dist    = t_dist;
                assign nb_reached = t_reached;
                assign nb_open    = t_open;
            end
            else
            begin : g_mid
                assign nb_dist    = c_dist[gi+1];
                assign nb_reached = c_reached[gi+1];
                assign nb_open    = c_open[gi+1];
            end
            dsp_cell #(.DW(DW)) u_cell
            (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (cctrl),
                .init_reached (src_reg == NW'(gi)),
                .in_dist      (nb_dist),
                .in_reached   (nb_reached),
                .in_open      (nb_open),
                .est          (c_dist[gi]),
                .reached      (c_reached[gi]),
                .open         (c_open[gi])
            );
        end
    endgenerate

    // Edge memory control
    always_comb
    begin
        em_we    = 1'b0;
        em_waddr = {NW'(node_a), NW'(node_b)};
        em_wdata = SW'(weight);
        case (state_reg)
            ST_CLEAR:
            begin
                em_we    = 1'b1;
                em_waddr = clr_reg;
                em_wdata = '0;
            end
            ST_IDLE:
                em_we = in_valid && (mode_t'(mode) == MODE_SET) &&
                        (a_ext < CW'(MAX_NODES)) && (b_ext < CW'(MAX_NODES));
            ST_SET2:
            begin
                em_we    = 1'b1;
                em_waddr = set_addr_reg;
                em_wdata = set_w_reg;
            end
            default:
                em_we = 1'b0;
        endcase
    end

    assign em_raddr = (state_reg == ST_PASS) ? {u_reg, k_reg + NW'(1)} : {u_reg, NW'(0)};

    dsp_edge_mem #(.AW(AW), .DW(SW)) u_edge_mem
    (
        .clk   (clk),
        .we    (em_we),
        .waddr (em_waddr),
        .wdata (em_wdata),
        .raddr (em_raddr),
        .rdata (em_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PASS && relax)
            par_mem[k_reg] <= u_reg;
        par_rdata_reg <= par_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WALK)
            path_mem[len_reg[NW-1:0]] <= cur_reg;
        path_rdata_reg <= path_mem[e_idx_reg];
    end

    assign len_inc  = len_reg + CW'(1);
    assign dist_x   = XW'(dst_dist_reg);
    assign dist_sat = (dist_x > XW'(DIST_SAT)) ? DIST_SAT : DIST_W'(dist_x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            nc_reg        <= 6'd32;
            out_valid_reg <= 1'b0;
            have_u_reg    <= 1'b0;
            found_reg     <= 1'b0;
            k_reg         <= '0;
            len_reg       <= '0;
            e_idx_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
                nc_reg <= node_count;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == '1)
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        set_addr_reg <= {NW'(node_b), NW'(node_a)};
                        set_w_reg    <= SW'(weight);
                        src_reg      <= NW'(node_a);
                        dst_reg      <= NW'(node_b);
                        dst5_reg     <= node_b;
                        case (mode_t'(mode))
                            MODE_SET:
                                if (em_we)
                                    state_reg <= ST_SET2;
                            MODE_CLEAR:
                            begin
                                clr_reg   <= '0;
                                state_reg <= ST_CLEAR;
                            end
                            MODE_SOLVE:
                                if (a_ext >= n_act || b_ext >= n_act)
                                begin
                                    node_reg      <= node_b;
                                    dist_reg      <= '0;
                                    unr_reg       <= 1'b1;
                                    last_reg      <= 1'b1;
                                    out_valid_reg <= 1'b1;
                                    e_idx_reg     <= '0;
                                    state_reg     <= ST_OUT;
                                end
                                else
                                    state_reg <= ST_LOAD;
                            default:
                                state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_SET2:
                    state_reg <= ST_IDLE;
                ST_LOAD:
                begin
                    have_u_reg      <= 1'b0;
                    found_reg       <= 1'b0;
                    dst_reached_reg <= 1'b0;
                    k_reg           <= '0;
                    state_reg       <= ST_PASS;
                end
                ST_PRIME:
                begin
                    found_reg <= 1'b0;
                    k_reg     <= '0;
                    state_reg <= ST_PASS;
                end
                ST_PASS:
                begin
                    found_reg       <= pass_found;
                    best_reg        <= pass_best;
                    best_dist_reg   <= pass_best_dist;
                    dst_reached_reg <= pass_dst_reached;
                    if (k_reg == dst_reg)
                        dst_dist_reg <= t_dist;
                    k_reg <= k_reg + NW'(1);
                    if (k_reg == NW'(MAX_NODES - 1))
                    begin
                        if (pass_found)
                        begin
                            u_reg      <= pass_best;
                            du_reg     <= pass_best_dist;
                            have_u_reg <= 1'b1;
                            state_reg  <= ST_PRIME;
                        end
                        else if (!pass_dst_reached)
                        begin
                            node_reg      <= dst5_reg;
                            dist_reg      <= '0;
                            unr_reg       <= 1'b1;
                            last_reg      <= 1'b1;
                            out_valid_reg <= 1'b1;
                            e_idx_reg     <= '0;
                            state_reg     <= ST_OUT;
                        end
                        else
                        begin
                            cur_reg   <= dst_reg;
                            len_reg   <= '0;
                            state_reg <= ST_WALK;
                        end
                    end
                end
                ST_WALK:
                begin
                    len_reg <= len_inc;
                    if (cur_reg == src_reg || len_inc == n_act)
                    begin
                        e_idx_reg <= len_reg[NW-1:0];
                        state_reg <= ST_EMIT_RD;
                    end
                    else
                        state_reg <= ST_WALK_WAIT;
                end
                ST_WALK_WAIT:
                begin
                    cur_reg   <= par_rdata_reg;
                    state_reg <= ST_WALK;
                end
                ST_EMIT_RD:
                    state_reg <= ST_EMIT_LD;
                ST_EMIT_LD:
                begin
                    node_reg      <= NODE_W'(path_rdata_reg);
                    dist_reg      <= dist_sat;
                    unr_reg       <= 1'b0;
                    last_reg      <= (e_idx_reg == '0);
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_reg)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            e_idx_reg <= e_idx_reg - NW'(1);
                            state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign node           = node_reg;
    assign total_distance = dist_reg;
    assign unreachable    = unr_reg;
    assign last           = last_reg;

endmodule

### rtl/dsp_checker.sv
// Port-level checks for the shortest-path block, bound to the top level.
module dsp_checker
    import dsp_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [NODE_W-1:0]   node,
    input logic [DIST_W-1:0]   total_distance,
    input logic                unreachable,
    input logic                last
);

    // held word stays put while the receiver stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(node) &&
        $stable(total_distance) && $stable(unreachable) && $stable(last))
        else $error("result word changed while stalled");

    a_unr_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unreachable |-> last)
        else $error("unreachable word not marked last");

    a_unr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unreachable |-> total_distance == '0)
        else $error("unreachable word carries a distance");

    // commands are only taken when no result word is pending
    a_idle_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input ready while a result word is pending");

endmodule

bind dijkstra_shortest_path_top dsp_checker u_dsp_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .node           (node),
    .total_distance (total_distance),
    .unreachable    (unreachable),
    .last           (last)
);
